[rtl/mvm_pkg.sv]
// shared constants, codes and stage types for the matrix-vector multiply block
`default_nettype none

package mvm_pkg;

  // store sizes
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int COL_AW      = $clog2(MAX_COLUMNS);
  localparam int ROW_AW      = $clog2(MAX_ROWS);

  // field and register widths
  localparam int OP_W     = 2;
  localparam int INDEX_W  = 10;
  localparam int VAL_W    = 16;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int SUM_W    = 32;
  localparam int ACC_W    = 48;
  localparam int CNT_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int BIAS_SHIFT = 8;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // opcodes of an input word
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_VECTOR = 2'd0,
    OP_LOAD_BIAS   = 2'd1,
    OP_MATRIX      = 2'd2
  } opcode_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE  = 2'd2;

  // product stage handed to the accumulator
  typedef struct packed {
    logic                     valid;
    logic                     row_end;
    logic                     last_row;
    logic [ROW_AW-1:0]        row;
    logic                     bias_en;
    logic signed [VAL_W-1:0]  bias;
    logic signed [PROD_W-1:0] product;
  } stage_t;

  // one result word
  typedef struct packed {
    logic [INDEX_W-1:0]      row_index;
    logic signed [SUM_W-1:0] row_sum;
    logic                    saturated;
    logic                    last_row;
  } result_t;

endpackage

`default_nettype wire

[rtl/mvm_if.sv]
// valid/ready channel interfaces for input elements and row results
`default_nettype none

interface mvm_in_if;
  logic                           valid;
  logic                           ready;
  logic [mvm_pkg::OP_W-1:0]       opcode;
  logic [mvm_pkg::INDEX_W-1:0]    load_index;
  logic signed [mvm_pkg::VAL_W-1:0] value;

  modport source (output valid, output opcode, output load_index, output value,
                  input ready);
  modport sink   (input valid, input opcode, input load_index, input value,
                  output ready);
endinterface

interface mvm_out_if;
  logic                             valid;
  logic                             ready;
  logic [mvm_pkg::INDEX_W-1:0]      row_index;
  logic signed [mvm_pkg::SUM_W-1:0] row_sum;
  logic                             saturated;
  logic                             last_row;

  modport source (output valid, output row_index, output row_sum, output saturated,
                  output last_row, input ready);
  modport sink   (input valid, input row_index, input row_sum, input saturated,
                  input last_row, output ready);
endinterface

`default_nettype wire

[rtl/mvm_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/mvm_acc.sv]
// row accumulator: sums products, adds bias at row end and saturates to q16.16
`default_nettype none

module mvm_acc (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mvm_pkg::stage_t  stage,
  output logic                  push,
  output mvm_pkg::result_t      push_data
);
  import mvm_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] total;
  logic                    total_valid;
  logic [ROW_AW-1:0]       total_row;
  logic                    total_last;

  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] bias_term;
  logic                    in_range;

  // widen product and bias into the accumulator format
  always_comb begin
    prod_ext  = ACC_W'($signed(stage.product));
    bias_term = '0;
    if (stage.bias_en) begin
      bias_term = $signed({{(ACC_W-VAL_W-BIAS_SHIFT){stage.bias[VAL_W-1]}},
                           stage.bias, {BIAS_SHIFT{1'b0}}});
    end
  end

  // accumulate, close the row on its last column
  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      total_valid <= 1'b0;
    end else begin
      total_valid <= stage.valid && stage.row_end;
      if (stage.valid) begin
        if (stage.row_end) begin
          acc <= '0;
        end else begin
          acc <= acc + prod_ext;
        end
      end
    end
  end

  // row total and its tags
  always_ff @(posedge clk) begin
    if (stage.valid && stage.row_end) begin
      total      <= acc + prod_ext + bias_term;
      total_row  <= stage.row;
      total_last <= stage.last_row;
    end
  end

  // clamp to the 32-bit range
  always_comb begin
    in_range = (&total[ACC_W-1:SUM_W-1]) || !(|total[ACC_W-1:SUM_W-1]);
    push                = total_valid;
    push_data.row_index = INDEX_W'(total_row);
    push_data.last_row  = total_last;
    push_data.saturated = !in_range;
    if (in_range) begin
      push_data.row_sum = total[SUM_W-1:0];
    end else if (total[ACC_W-1]) begin
      push_data.row_sum = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      push_data.row_sum = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

[rtl/mvm_fifo.sv]
// small result queue between the accumulator and the output channel
`default_nettype none

module mvm_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire mvm_pkg::result_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output mvm_pkg::result_t      pop_data
);
  import mvm_pkg::*;

  result_t            entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               pop;

  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

[rtl/matrix_vector_multiply_bias.sv]
// matrix-vector multiply with bias, y = A*x + b, q8.8 in and q16.16 out
// throughput: one element word, one multiply-accumulate per cycle if the queue has room
// path: a row's last element passes the store read, multiply, row total and result
// queue registers before its result word is offered; eight results queue
// reset clears positions, accumulator, queue and bias enable and sets counts to 1024; stores are
// not cleared and hold whatever was last loaded
`default_nettype none

module matrix_vector_multiply_bias (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mvm_in_if.sink                               elements,
  mvm_out_if.source                            results,
  input  wire logic                            cfg_we,
  input  wire logic [mvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mvm_pkg::CNT_W-1:0]       cfg_data
);
  import mvm_pkg::*;

  // configuration
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic             bias_enable;

  // positions
  logic [COL_AW-1:0] column_position;
  logic [ROW_AW-1:0] row_position;

  // control
  logic             accept;
  logic             is_matrix;
  logic [CNT_W-1:0] cols_eff;
  logic [CNT_W-1:0] rows_eff;
  logic             col_end;
  logic             row_last;
  logic             vec_we;
  logic             bias_we;

  // store read stage
  logic                    s1_valid;
  logic                    s1_end;
  logic                    s1_last;
  logic [ROW_AW-1:0]       s1_row;
  logic                    s1_bias_en;
  logic signed [VAL_W-1:0] s1_value;
  logic [VAL_W-1:0]        vec_rdata;
  logic [VAL_W-1:0]        bias_rdata;

  // product stage and result path
  stage_t           s2;
  logic             push;
  result_t          push_data;
  result_t          pop_data;
  logic [FIFO_AW:0] pending;
  logic             will_emit;
  logic             out_take;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CNT_W'(MAX_COLUMNS);
      row_count    <= CNT_W'(MAX_ROWS);
      bias_enable  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLUMN_COUNT: column_count <= cfg_data;
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_BIAS_ENABLE:  bias_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective counts and row/pass end detection
  always_comb begin
    if (column_count == '0) begin
      cols_eff = CNT_W'(1);
    end else if (column_count > CNT_W'(MAX_COLUMNS)) begin
      cols_eff = CNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = column_count;
    end
    if (row_count == '0) begin
      rows_eff = CNT_W'(1);
    end else if (row_count > CNT_W'(MAX_ROWS)) begin
      rows_eff = CNT_W'(MAX_ROWS);
    end else begin
      rows_eff = row_count;
    end
    col_end  = (CNT_W'(column_position) + CNT_W'(1)) >= cols_eff;
    row_last = (CNT_W'(row_position) + CNT_W'(1)) >= rows_eff;
  end

  // handshake and store writes
  assign accept    = elements.valid && elements.ready;
  assign is_matrix = (elements.opcode == OP_MATRIX);
  assign vec_we    = accept && (elements.opcode == OP_LOAD_VECTOR) &&
                     (CNT_W'(elements.load_index) < CNT_W'(MAX_COLUMNS));
  assign bias_we   = accept && (elements.opcode == OP_LOAD_BIAS) &&
                     (CNT_W'(elements.load_index) < CNT_W'(MAX_ROWS));
  assign will_emit = accept && is_matrix && col_end;
  assign out_take  = results.valid && results.ready;

  // room for every result that could still be in flight
  assign elements.ready = (pending < (FIFO_AW+1)'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + (FIFO_AW+1)'(will_emit) - (FIFO_AW+1)'(out_take);
    end
  end

  // column and row positions
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (accept && is_matrix) begin
      if (col_end) begin
        column_position <= '0;
        row_position    <= row_last ? '0 : row_position + 1'b1;
      end else begin
        column_position <= column_position + 1'b1;
      end
    end
  end

  mvm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_vector_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (elements.load_index[COL_AW-1:0]),
    .wdata (elements.value),
    .re    (accept && is_matrix),
    .raddr (column_position),
    .rdata (vec_rdata)
  );

  mvm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (elements.load_index[ROW_AW-1:0]),
    .wdata (elements.value),
    .re    (accept && is_matrix),
    .raddr (row_position),
    .rdata (bias_rdata)
  );

  // tags riding alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && is_matrix;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_matrix) begin
      s1_end     <= col_end;
      s1_last    <= row_last;
      s1_row     <= row_position;
      s1_bias_en <= bias_enable;
      s1_value   <= elements.value;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1_valid;
    end
    if (s1_valid) begin
      s2.row_end  <= s1_end;
      s2.last_row <= s1_last;
      s2.row      <= s1_row;
      s2.bias_en  <= s1_bias_en;
      s2.bias     <= $signed(bias_rdata);
      s2.product  <= PROD_W'(s1_value) * PROD_W'($signed(vec_rdata));
    end
  end

  mvm_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .stage     (s2),
    .push      (push),
    .push_data (push_data)
  );

  mvm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop_valid (results.valid),
    .pop_ready (results.ready),
    .pop_data  (pop_data)
  );

  // output word
  assign results.row_index = pop_data.row_index;
  assign results.row_sum   = pop_data.row_sum;
  assign results.saturated = pop_data.saturated;
  assign results.last_row  = pop_data.last_row;

endmodule

`default_nettype wire
